// File: src/ure_pkg.sv
`timescale 1ns / 1ps

package ure_pkg;

  // register widths and counts
  localparam int unsigned CntW    = 16;
  localparam int unsigned UpcW    = 8;
  localparam int unsigned DistW   = 19;
  localparam int unsigned StatW   = 2;
  localparam int unsigned RemW    = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDatW  = 8;
  localparam int unsigned OutDatW = 24;

  // speed of sound divisor, us per cm round trip
  localparam logic [RemW-1:0] SoundDiv = 6'd58;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PRESCALE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEAD     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HIGH     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_UPC      = 3'd4;

  // register reset values
  localparam logic [CntW-1:0] PRESCALE_RST = 16'd1024;
  localparam logic [CntW-1:0] LEAD_RST     = 16'd16;
  localparam logic [CntW-1:0] HIGH_RST     = 16'd160;
  localparam logic [CntW-1:0] TIMEOUT_RST  = 16'd65000;
  localparam logic [UpcW-1:0] UPC_RST      = 8'd64;

  // status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NO_ECHO   = 2'd1;
  localparam logic [StatW-1:0] ST_ECHO_LONG = 2'd2;

  // phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_RISE = 3'd3;
  localparam logic [2:0] PH_MEAS = 3'd4;

  typedef struct packed {
    logic [CntW-1:0] prescale_ticks;
    logic [CntW-1:0] lead_low_ticks;
    logic [CntW-1:0] trigger_high_ticks;
    logic [CntW-1:0] timeout_counts;
    logic [UpcW-1:0] us_per_count;
  } ure_cfg_t;

  // packed so that trigger_level sits in bit 0
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [DistW-1:0] distance_cm;
    logic             done_res;
    logic             busy_res;
    logic             trigger_level;
  } ure_result_t;

  // split a sum below 5*58+58 into quotient and remainder by 58
  function automatic logic [RemW+2:0] div58(input logic [8:0] s);
    logic [2:0]      q;
    logic [8:0]      sub;
    logic [RemW+2:0] res;
    if (s >= 9'd290) begin
      q = 3'd5; sub = 9'd290;
    end else if (s >= 9'd232) begin
      q = 3'd4; sub = 9'd232;
    end else if (s >= 9'd174) begin
      q = 3'd3; sub = 9'd174;
    end else if (s >= 9'd116) begin
      q = 3'd2; sub = 9'd116;
    end else if (s >= {3'd0, SoundDiv}) begin
      q = 3'd1; sub = {3'd0, SoundDiv};
    end else begin
      q = 3'd0; sub = 9'd0;
    end
    res = {q, 6'(s - sub)};
    return res;
  endfunction

endpackage

// File: src/ure_cfg.sv
`timescale 1ns / 1ps

module ure_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ure_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ure_pkg::CfgDatW-1:0]  cfg_data,
  output ure_pkg::ure_cfg_t            cfg_o
);
  import ure_pkg::*;

  ure_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale_ticks     <= PRESCALE_RST;
      cfg_r.lead_low_ticks     <= LEAD_RST;
      cfg_r.trigger_high_ticks <= HIGH_RST;
      cfg_r.timeout_counts     <= TIMEOUT_RST;
      cfg_r.us_per_count       <= UPC_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRESCALE: cfg_r.prescale_ticks     <= cfg_data;
        REG_LEAD:     cfg_r.lead_low_ticks     <= cfg_data;
        REG_HIGH:     cfg_r.trigger_high_ticks <= cfg_data;
        REG_TIMEOUT:  cfg_r.timeout_counts     <= cfg_data;
        REG_UPC:      cfg_r.us_per_count       <= cfg_data[UpcW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/ure_core.sv
`timescale 1ns / 1ps

module ure_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 start_req,
  input  logic                 echo_level,
  input  ure_pkg::ure_cfg_t    cfg,
  output ure_pkg::ure_result_t result
);
  import ure_pkg::*;

  logic [2:0]       phase_r, phase_nxt;
  logic [CntW-1:0]  ps_cnt_r, ps_cnt_nxt;
  logic [CntW-1:0]  echo_cnt_r, echo_cnt_nxt;
  logic [CntW-1:0]  trig_tmr_r, trig_tmr_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;
  logic [StatW-1:0] stat_r, stat_nxt;
  logic [DistW-1:0] quo_r, quo_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt;
  logic             done;

  logic [CntW:0]    ps_inc;
  logic             ps_hit;
  logic [CntW-1:0]  ps_adv;
  logic [CntW:0]    tmr_inc;
  logic             timed_out;
  logic [RemW+2:0]  dm;

  // prescaler, trigger timer and timeout compares
  assign ps_inc    = {1'b0, ps_cnt_r} + 17'd1;
  assign ps_hit    = ps_inc >= {1'b0, cfg.prescale_ticks};
  assign ps_adv    = ps_hit ? '0 : ps_inc[CntW-1:0];
  assign tmr_inc   = {1'b0, trig_tmr_r} + 17'd1;
  assign timed_out = echo_cnt_r >= cfg.timeout_counts;

  // running count * us_per_count, kept as quotient and remainder by 58
  assign dm = div58(9'(rem_r) + 9'(cfg.us_per_count));

  // phase sequencer
  always_comb begin
    phase_nxt    = phase_r;
    ps_cnt_nxt   = ps_cnt_r;
    echo_cnt_nxt = echo_cnt_r;
    trig_tmr_nxt = trig_tmr_r;
    dist_nxt     = dist_r;
    stat_nxt     = stat_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    done         = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          trig_tmr_nxt = '0;
          phase_nxt    = (cfg.lead_low_ticks == '0) ? PH_HIGH : PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (tmr_inc >= {1'b0, cfg.lead_low_ticks}) begin
          trig_tmr_nxt = '0;
          phase_nxt    = PH_HIGH;
        end else begin
          trig_tmr_nxt = tmr_inc[CntW-1:0];
        end
      end
      PH_HIGH: begin
        if (tmr_inc >= {1'b0, cfg.trigger_high_ticks}) begin
          trig_tmr_nxt = '0;
          ps_cnt_nxt   = '0;
          echo_cnt_nxt = '0;
          phase_nxt    = PH_RISE;
        end else begin
          trig_tmr_nxt = tmr_inc[CntW-1:0];
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          ps_cnt_nxt   = '0;
          echo_cnt_nxt = '0;
          quo_nxt      = '0;
          rem_nxt      = '0;
          phase_nxt    = PH_MEAS;
        end else begin
          ps_cnt_nxt = ps_adv;
          if (ps_hit) begin
            if (timed_out) begin
              done     = 1'b1;
              dist_nxt = '0;
              stat_nxt = ST_NO_ECHO;
            end else begin
              echo_cnt_nxt = echo_cnt_r + 16'd1;
            end
          end
        end
      end
      PH_MEAS: begin
        if (!echo_level) begin
          done     = 1'b1;
          dist_nxt = quo_r;
          stat_nxt = ST_OK;
        end else begin
          ps_cnt_nxt = ps_adv;
          if (ps_hit) begin
            if (timed_out) begin
              done     = 1'b1;
              dist_nxt = '0;
              stat_nxt = ST_ECHO_LONG;
            end else begin
              echo_cnt_nxt = echo_cnt_r + 16'd1;
              quo_nxt      = quo_r + 19'(dm[RemW+2:RemW]);
              rem_nxt      = dm[RemW-1:0];
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // finishing returns to idle with counters cleared
    if (done || phase_nxt == PH_IDLE) begin
      phase_nxt    = PH_IDLE;
      ps_cnt_nxt   = '0;
      echo_cnt_nxt = '0;
      trig_tmr_nxt = '0;
      quo_nxt      = '0;
      rem_nxt      = '0;
    end
  end

  // result for this tick, taken after the update
  always_comb begin
    result.trigger_level = (phase_nxt == PH_HIGH);
    result.busy_res      = (phase_nxt != PH_IDLE);
    result.done_res      = done;
    result.distance_cm   = dist_nxt;
    result.status        = stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      ps_cnt_r   <= '0;
      echo_cnt_r <= '0;
      trig_tmr_r <= '0;
      dist_r     <= '0;
      stat_r     <= ST_OK;
      quo_r      <= '0;
      rem_r      <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      ps_cnt_r   <= ps_cnt_nxt;
      echo_cnt_r <= echo_cnt_nxt;
      trig_tmr_r <= trig_tmr_nxt;
      dist_r     <= dist_nxt;
      stat_r     <= stat_nxt;
      quo_r      <= quo_nxt;
      rem_r      <= rem_nxt;
    end
  end

endmodule

// File: src/ure_skid.sv
`timescale 1ns / 1ps

module ure_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ure_pkg::ure_result_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ure_pkg::ure_result_t out_data
);
  import ure_pkg::*;

  ure_result_t main_r, skid_r;
  logic        main_valid_r, skid_valid_r;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // control: main stage feeds the port, skid catches an item while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ready) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!main_valid_r || out_ready) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// File: src/ultrasonic_echo_ranger.sv
// an accepted tick's result is registered in the output stage, offered on out_tvalid
// throughput: one tick per cycle while in_tready is high; the two-entry output stage
//   takes one more tick after out_tready drops, then in_tready falls
// reset: synchronous active-low rst_n clears the phase, counters and last result
//   and loads the register defaults; no clearing pass is needed
`timescale 1ns / 1ps

module ultrasonic_echo_ranger (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] start_req, [1] echo_level, [7:2] zero
  input  logic [ure_pkg::InDatW-1:0]          in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [21:3] distance_cm, [23:22] status
  output logic [ure_pkg::OutDatW-1:0]         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ure_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ure_pkg::CfgDatW-1:0]         cfg_data
);
  import ure_pkg::*;

  ure_cfg_t    cfg;
  ure_result_t core_res, out_res;
  logic        fire;

  assign fire      = in_tvalid && in_tready;
  assign out_tdata = out_res;

  ure_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ure_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .start_req  (in_tdata[0]),
    .echo_level (in_tdata[1]),
    .cfg        (cfg),
    .result     (core_res)
  );

  ure_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (core_res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

endmodule

// File: src/ure_checker.sv
`timescale 1ns / 1ps

module ure_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ure_pkg::OutDatW-1:0] out_tdata
);
  import ure_pkg::*;

  // reset empties the output stage
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && $past(out_tvalid && !out_tready)))
    else $error("input stalled with no pending result");

  // a finishing tick leaves the block idle with trigger low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> (!out_tdata[1] && !out_tdata[0]))
    else $error("done while busy or triggering");

  // trigger only while busy
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> out_tdata[1])
    else $error("trigger high while idle");

  // a timeout reports zero distance
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[23:22] == ST_NO_ECHO || out_tdata[23:22] == ST_ECHO_LONG))
      |-> (out_tdata[21:3] == '0))
    else $error("nonzero distance on timeout");

endmodule

bind ultrasonic_echo_ranger ure_checker u_ure_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/tb_ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
  import ure_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int RandPhases  = 8;
  localparam int PhaseTicks  = 20;
  localparam int SteadyPhase = 3;
  localparam int HoldPhase   = 5;
  localparam int DirRows     = 35;

  // index that maps to no register, writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               start;
    logic               echo;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDatW-1:0] val;
    logic               typed;
    ure_result_t        want;
  } dir_row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDatW-1:0]   in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDatW-1:0]  out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDatW-1:0]  cfg_data   = '0;

  // predictor state and register shadow
  ure_cfg_t            cfg_shadow = '{PRESCALE_RST, LEAD_RST, HIGH_RST, TIMEOUT_RST, UPC_RST};
  logic [2:0]          rng_phase  = PH_IDLE;
  logic [CntW-1:0]     psc_cnt    = '0;
  logic [CntW-1:0]     echo_cnt   = '0;
  logic [CntW-1:0]     trig_tmr   = '0;
  logic [DistW-1:0]    dist_hold  = '0;
  logic [StatW-1:0]    stat_hold  = '0;

  ure_result_t         due_readings[$];
  dir_row_t            dir_rows[DirRows];

  // handshake pacing shared with the receiver
  logic                steady     = 1'b0;
  logic                hold_req   = 1'b0;

  int                  mismatches = 0;
  int                  quiet      = 0;
  int                  ticks_sent = 0;
  int                  busy_ticks = 0;
  int                  cfg_writes = 0;
  int                  n_ok       = 0;
  int                  n_no_echo  = 0;
  int                  n_too_long = 0;
  int                  max_dist   = 0;
  ure_result_t         seen_rd;
  ure_result_t         due_rd;

  ultrasonic_echo_ranger dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ure_result_t ranger_out(input logic trig, input logic busy,
                                             input logic done, input logic [DistW-1:0] dist_cm,
                                             input logic [StatW-1:0] st);
    ure_result_t r;
    r.trigger_level = trig;
    r.busy_res      = busy;
    r.done_res      = done;
    r.distance_cm   = dist_cm;
    r.status        = st;
    return r;
  endfunction

  // end of a measurement, back to idle with the new reading held
  function automatic void close_reading(input logic [DistW-1:0] dist_cm,
                                        input logic [StatW-1:0] st);
    dist_hold = dist_cm;
    stat_hold = st;
    rng_phase = PH_IDLE;
    psc_cnt   = '0;
    echo_cnt  = '0;
    trig_tmr  = '0;
  endfunction

  // steps the prescaler and, on its wrap, one count of the wait; 1 when the wait expires
  function automatic logic count_expired();
    psc_cnt = psc_cnt + 1'b1;
    if (psc_cnt < cfg_shadow.prescale_ticks) return 1'b0;
    psc_cnt = '0;
    if (echo_cnt >= cfg_shadow.timeout_counts) return 1'b1;
    echo_cnt = echo_cnt + 1'b1;
    return 1'b0;
  endfunction

  // advances the ranger by one tick and gives the reading it shows after it
  function automatic ure_result_t ranger_tick(input logic start, input logic echo);
    logic        fin;
    int unsigned prod;
    fin = 1'b0;
    case (rng_phase)
      PH_IDLE: begin
        if (start) begin
          trig_tmr  = '0;
          rng_phase = (cfg_shadow.lead_low_ticks == '0) ? PH_HIGH : PH_LEAD;
        end
      end
      PH_LEAD: begin
        trig_tmr = trig_tmr + 1'b1;
        if (trig_tmr >= cfg_shadow.lead_low_ticks) begin
          trig_tmr  = '0;
          rng_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        trig_tmr = trig_tmr + 1'b1;
        if (trig_tmr >= cfg_shadow.trigger_high_ticks) begin
          trig_tmr  = '0;
          psc_cnt   = '0;
          echo_cnt  = '0;
          rng_phase = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo) begin
          psc_cnt   = '0;
          echo_cnt  = '0;
          rng_phase = PH_MEAS;
        end else if (count_expired()) begin
          close_reading('0, ST_NO_ECHO);
          fin = 1'b1;
        end
      end
      PH_MEAS: begin
        if (!echo) begin
          prod = 32'(echo_cnt) * 32'(cfg_shadow.us_per_count);
          close_reading(DistW'(prod / 32'(SoundDiv)), ST_OK);
          fin = 1'b1;
        end else if (count_expired()) begin
          close_reading('0, ST_ECHO_LONG);
          fin = 1'b1;
        end
      end
      default: close_reading(dist_hold, stat_hold);
    endcase
    return ranger_out(rng_phase == PH_HIGH, rng_phase != PH_IDLE, fin, dist_hold, stat_hold);
  endfunction

  // directed rows: plain tick, tick with a typed reading, register write
  function automatic dir_row_t t_row(input logic s, input logic e);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_TICK;
    r.start = s;
    r.echo  = e;
    return r;
  endfunction

  function automatic dir_row_t k_row(input logic s, input logic e, input ure_result_t want);
    dir_row_t r;
    r       = t_row(s, e);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t c_row(input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDatW-1:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // offer one tick, with random gaps unless steady, and queue its reading
  task automatic send_tick(input logic start, input logic echo,
                           input logic typed = 1'b0, input ure_result_t want = '0);
    logic [2:0]  prior;
    ure_result_t reading;
    if (!steady) begin
      while ($urandom_range(3) == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDatW-2){1'b0}}, echo, start};
    do @(posedge clk); while (!in_tready);
    prior   = rng_phase;
    reading = ranger_tick(start, echo);
    due_readings.push_back(typed ? want : reading);
    ticks_sent++;
    if (prior != PH_IDLE || rng_phase != PH_IDLE) busy_ticks++;
  endtask

  // finish any measurement, let all readings drain, then write one register
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    while (rng_phase != PH_IDLE) send_tick(1'b0, rng_phase == PH_RISE);
    in_tvalid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRESCALE: cfg_shadow.prescale_ticks     = val;
      REG_LEAD:     cfg_shadow.lead_low_ticks     = val;
      REG_HIGH:     cfg_shadow.trigger_high_ticks = val;
      REG_TIMEOUT:  cfg_shadow.timeout_counts     = val;
      REG_UPC:      cfg_shadow.us_per_count       = val[UpcW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic load_cfg(input logic [CfgDatW-1:0] psc, input logic [CfgDatW-1:0] lead,
                          input logic [CfgDatW-1:0] hi, input logic [CfgDatW-1:0] tmo,
                          input logic [CfgDatW-1:0] upc);
    write_reg(REG_PRESCALE, psc);
    write_reg(REG_LEAD, lead);
    write_reg(REG_HIGH, hi);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_UPC, upc);
  endtask

  // one ranging cycle: start, trigger, rise_wait low ticks, echo_len high ticks, then low
  task automatic measure(input int rise_wait, input int echo_len);
    int n;
    send_tick(1'b1, 1'($urandom_range(1)));
    while (rng_phase == PH_LEAD || rng_phase == PH_HIGH)
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    for (n = 0; n < rise_wait && rng_phase == PH_RISE; n++)
      send_tick(1'($urandom_range(1)), 1'b0);
    for (n = 0; n < echo_len && rng_phase != PH_IDLE; n++)
      send_tick(1'($urandom_range(1)), 1'b1);
    if (rng_phase != PH_IDLE) send_tick(1'($urandom_range(1)), 1'b0);
  endtask

  // receiver: random stalls, steady stretches, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= steady || ($urandom_range(3) != 0);
    end
  end

  // reading checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_rd = out_tdata;
      if (due_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: trig %b busy %b done %b dist %0d status %0d",
                   seen_rd.trigger_level, seen_rd.busy_res, seen_rd.done_res,
                   seen_rd.distance_cm, seen_rd.status);
      end else begin
        due_rd = due_readings.pop_front();
        if (seen_rd.trigger_level !== due_rd.trigger_level ||
            seen_rd.busy_res !== due_rd.busy_res ||
            seen_rd.done_res !== due_rd.done_res ||
            seen_rd.distance_cm !== due_rd.distance_cm ||
            seen_rd.status !== due_rd.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading mismatch at %0t: exp trig %b busy %b done %b dist %0d st %0d, %s",
                     $realtime, due_rd.trigger_level, due_rd.busy_res, due_rd.done_res,
                     due_rd.distance_cm, due_rd.status,
                     $sformatf("got trig %b busy %b done %b dist %0d st %0d",
                               seen_rd.trigger_level, seen_rd.busy_res, seen_rd.done_res,
                               seen_rd.distance_cm, seen_rd.status));
        end
      end
      if (seen_rd.done_res === 1'b1) begin
        case (seen_rd.status)
          ST_OK:        n_ok++;
          ST_NO_ECHO:   n_no_echo++;
          ST_ECHO_LONG: n_too_long++;
          default: ;
        endcase
        if (int'(seen_rd.distance_cm) > max_dist) max_dist = int'(seen_rd.distance_cm);
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("watchdog: nothing moved for %0d cycles", QuietLimit);
        $display("tb_ultrasonic_echo_ranger failed");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int target;
    int span;
    int psc;
    int tmo;

    // after reset: idle, then a start on the default lead-low time
    // then minimal timing: no lead time, both timeouts, a short echo
    // then zero prescale, zero pulse width and zero timeout
    dir_rows = '{
      k_row(1'b0, 1'b1, ranger_out(1'b0, 1'b0, 1'b0, '0, ST_OK)),
      k_row(1'b1, 1'b0, ranger_out(1'b0, 1'b1, 1'b0, '0, ST_OK)),
      c_row(REG_PRESCALE, 16'd1),
      c_row(REG_LEAD, 16'd0),
      c_row(REG_HIGH, 16'd1),
      c_row(REG_TIMEOUT, 16'd3),
      c_row(REG_UPC, 16'h00ff),
      c_row(REG_NONE, 16'hffff),
      k_row(1'b1, 1'b0, ranger_out(1'b1, 1'b1, 1'b0, '0, ST_OK)),
      t_row(1'b1, 1'b0),
      t_row(1'b0, 1'b0),
      t_row(1'b0, 1'b0),
      t_row(1'b0, 1'b0),
      k_row(1'b0, 1'b0, ranger_out(1'b0, 1'b0, 1'b1, '0, ST_NO_ECHO)),
      t_row(1'b1, 1'b1),
      t_row(1'b0, 1'b1),
      t_row(1'b0, 1'b1),
      t_row(1'b0, 1'b1),
      t_row(1'b0, 1'b1),
      t_row(1'b0, 1'b1),
      k_row(1'b1, 1'b1, ranger_out(1'b0, 1'b0, 1'b1, '0, ST_ECHO_LONG)),
      t_row(1'b1, 1'b0),
      t_row(1'b0, 1'b0),
      t_row(1'b0, 1'b1),
      t_row(1'b0, 1'b1),
      t_row(1'b0, 1'b0),
      c_row(REG_PRESCALE, 16'd0),
      c_row(REG_LEAD, 16'd2),
      c_row(REG_HIGH, 16'd0),
      c_row(REG_TIMEOUT, 16'd0),
      t_row(1'b1, 1'b0),
      t_row(1'b0, 1'b0),
      t_row(1'b0, 1'b0),
      t_row(1'b0, 1'b0),
      k_row(1'b0, 1'b0, ranger_out(1'b0, 1'b0, 1'b1, '0, ST_NO_ECHO))
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      else
        send_tick(dir_rows[r].start, dir_rows[r].echo, dir_rows[r].typed, dir_rows[r].want);
    end

    // random part: small random timing settings, random scale, mostly complete measurements
    for (ph = 0; ph < RandPhases; ph++) begin
      psc = $urandom_range(3);
      tmo = $urandom_range(10);
      load_cfg(16'(psc), 16'($urandom_range(4)), 16'($urandom_range(3)), 16'(tmo),
               16'($urandom));
      steady = (ph == SteadyPhase);
      if (ph == HoldPhase) hold_req = 1'b1;
      span   = (tmo + 1) * ((psc == 0) ? 1 : psc);
      target = busy_ticks + PhaseTicks;
      while (busy_ticks < target) begin
        if ($urandom_range(7) == 0)
          repeat ($urandom_range(4, 1)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          measure($urandom_range(span + 2), $urandom_range(span + 2));
      end
    end

    // extremes: widest timeout with the largest scale, slowest prescaler, zero timeout
    steady = 1'b1;
    load_cfg(16'd1, 16'd0, 16'd1, 16'hffff, 16'h00ff);
    measure(2, 40);
    load_cfg(16'hffff, 16'd1, 16'd1, 16'd1, 16'hffff);
    measure(2, 20);
    load_cfg(16'd1, 16'd0, 16'd1, 16'd0, 16'd1);
    measure(0, 0);

    // drain and settle
    in_tvalid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("run covered %0d ticks, %0d inside measurements, %0d register writes",
             ticks_sent, busy_ticks, cfg_writes);
    $display("readings: %0d ok, %0d echo never rose, %0d echo too long, farthest %0d cm",
             n_ok, n_no_echo, n_too_long, max_dist);
    if (due_readings.size() != 0) $display("%0d readings never came out", due_readings.size());
    if (mismatches == 0 && due_readings.size() == 0) begin
      $display("tb_ultrasonic_echo_ranger passed");
    end else begin
      $display("%0d bad readings", mismatches);
      $display("tb_ultrasonic_echo_ranger failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ure_pkg.sv
src/ure_cfg.sv
src/ure_core.sv
src/ure_skid.sv
src/ultrasonic_echo_ranger.sv
src/ure_checker.sv
sim/tb_ultrasonic_echo_ranger.sv
